/* design/rmpa_pkg.sv */
// ----------------------------------------------------------------------------
// rmpa_pkg
// Types and constants shared by the region moment and perimeter accumulator.
// ----------------------------------------------------------------------------
package rmpa_pkg;

    localparam int LABEL_W = 8;
    localparam int AREA_W  = 21;
    localparam int SUM_W   = 30;
    localparam int PERIM_W = 21;
    localparam int CFG_W   = 11;

    localparam logic [AREA_W-1:0]  AREA_MAX  = 21'd1048576;
    localparam logic [SUM_W-1:0]   SUM_MAX   = 30'h3FFF_FFFF;
    localparam logic [PERIM_W-1:0] PERIM_MAX = 21'd1048576;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [AREA_W-1:0]  area;
        logic [SUM_W-1:0]   sum_x;
        logic [SUM_W-1:0]   sum_y;
        logic [PERIM_W-1:0] perimeter;
    } result_t;

    typedef struct packed {
        logic [AREA_W-1:0] area;
        logic [SUM_W-1:0]  sum_x;
        logic [SUM_W-1:0]  sum_y;
    } moments_t;

endpackage

/* design/rmpa_if.sv */
// ----------------------------------------------------------------------------
// rmpa_if
// Valid/ready stream channels: label words in, per-label totals out.
// ----------------------------------------------------------------------------
interface rmpa_item_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic [rmpa_pkg::LABEL_W-1:0]  pixel_label;
    logic [rmpa_pkg::LABEL_W-1:0]  query_label;

    modport source (output valid, cmd, pixel_label, query_label, input ready);
    modport sink   (input valid, cmd, pixel_label, query_label, output ready);
endinterface

interface rmpa_result_if;
    logic                          valid;
    logic                          ready;
    logic [rmpa_pkg::AREA_W-1:0]   area;
    logic [rmpa_pkg::SUM_W-1:0]    sum_x;
    logic [rmpa_pkg::SUM_W-1:0]    sum_y;
    logic [rmpa_pkg::PERIM_W-1:0]  perimeter;

    modport source (output valid, area, sum_x, sum_y, perimeter, input ready);
    modport sink   (input valid, area, sum_x, sum_y, perimeter, output ready);
endinterface

/* design/rmpa_rmw_store.sv */
// ----------------------------------------------------------------------------
// rmpa_rmw_store
// Per-label store for read-modify-write: synchronous RAM with registered read,
// forwarding of the write made at the read edge, valid bits for reset zero.
// ----------------------------------------------------------------------------
module rmpa_rmw_store #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 21
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;
    logic [AW-1:0]    raddr_reg;
    logic [DEPTH-1:0] entry_valid_reg;
    logic             lw_valid_reg;
    logic [AW-1:0]    lw_addr_reg;
    logic [WIDTH-1:0] lw_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
            raddr_reg <= rd_addr;
        end
        lw_addr_reg <= wr_addr;
        lw_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            lw_valid_reg    <= 1'b0;
        end
        else
        begin
            lw_valid_reg <= wr_en;
            if (wr_en)
            begin
                entry_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // the RAM returns old data when written at the read edge
    always_comb
    begin
        if (lw_valid_reg && (lw_addr_reg == raddr_reg))
        begin
            rd_data = lw_data_reg;
        end
        else if (entry_valid_reg[raddr_reg])
        begin
            rd_data = rdata_reg;
        end
        else
        begin
            rd_data = '0;
        end
    end

endmodule

/* design/region_moment_perimeter_accumulator_core.sv */
// ----------------------------------------------------------------------------
// region_moment_perimeter_accumulator_core
// Per-label area, first moments and perimeter count over a labelled raster.
// ----------------------------------------------------------------------------
// One word is taken per clock while items.ready is high: pixel words and
// readout words alike enter back to back. A pixel's moments are updated
// from stage 1 and the perimeter verdict for the pixel up-left of it from
// stage 2; a readout result passes both stages and is offered through a
// four-entry output queue, so stalls on the result side stop input only
// when that queue and the readouts in flight fill it. The per-label totals
// live in two single-port-write RAMs (moments, perimeter) updated
// read-modify-write with forwarding; line buffers are two RAMs of MAX_WIDTH
// entries, with a fill mark so that columns not yet written read as zero.
// Totals are zero after reset without any clearing pass.
// ----------------------------------------------------------------------------
module region_moment_perimeter_accumulator_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int NUM_LABELS = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [rmpa_pkg::CFG_W-1:0]   cfg_data,
    rmpa_item_if.sink                    items,
    rmpa_result_if.source                results
);
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int DWW = $clog2(MAX_WIDTH + 1);
    localparam int DHW = $clog2(MAX_HEIGHT + 1);
    localparam int AW  = $clog2(NUM_LABELS);
    localparam int LW  = rmpa_pkg::LABEL_W;
    localparam int MW  = $bits(rmpa_pkg::moments_t);
    localparam int QD  = 4;

    // configuration
    logic [rmpa_pkg::CFG_W-1:0] width_reg, height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd640;
            height_reg <= 11'd480;
        end
        else if (cfg_we)
        begin
            if (cfg_index == rmpa_pkg::REG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else
            begin
                height_reg <= cfg_data;
            end
        end
    end

    logic [31:0]    wcfg, hcfg;
    logic [DWW-1:0] w_eff;
    logic [DHW-1:0] h_eff;

    always_comb
    begin
        wcfg = 32'(width_reg);
        hcfg = 32'(height_reg);
        if (wcfg < 32'd3)
        begin
            w_eff = DWW'(3);
        end
        else if (wcfg > 32'(MAX_WIDTH))
        begin
            w_eff = DWW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = DWW'(wcfg);
        end
        if (hcfg < 32'd3)
        begin
            h_eff = DHW'(3);
        end
        else if (hcfg > 32'(MAX_HEIGHT))
        begin
            h_eff = DHW'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = DHW'(hcfg);
        end
    end

    // input acceptance and raster position
    logic in_acc, pix_acc;
    logic [CW-1:0] col_reg, col_next, c_eff;
    logic [RW-1:0] row_reg, row_next, r_eff;

    assign in_acc  = items.valid && items.ready;
    assign pix_acc = in_acc && (items.cmd == rmpa_pkg::CMD_PIXEL);

    always_comb
    begin
        c_eff = (DWW'(col_reg) >= w_eff) ? CW'(w_eff - 1'b1) : col_reg;
        r_eff = (DHW'(row_reg) >= h_eff) ? RW'(h_eff - 1'b1) : row_reg;
        if ((DWW'(c_eff) + 1'b1) >= w_eff)
        begin
            col_next = '0;
            row_next = ((DHW'(r_eff) + 1'b1) >= h_eff) ? '0 : r_eff + 1'b1;
        end
        else
        begin
            col_next = c_eff + 1'b1;
            row_next = r_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1
    logic          s1_valid_reg, s1_cmd_reg;
    logic [LW-1:0] s1_pix_reg, s1_q_reg;
    logic [CW-1:0] s1_c_reg;
    logic [RW-1:0] s1_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_cmd_reg <= items.cmd;
            s1_pix_reg <= items.pixel_label;
            s1_q_reg   <= items.query_label;
            s1_c_reg   <= c_eff;
            s1_r_reg   <= r_eff;
        end
    end

    // line buffers
    logic [LW-1:0]  line_above [MAX_WIDTH];
    logic [LW-1:0]  line_two_above [MAX_WIDTH];
    logic [LW-1:0]  above_rd_reg, two_above_rd_reg;
    logic [LW-1:0]  above_c, two_above_c;
    logic           lb_hit_reg;
    logic [DWW-1:0] lb_fill_reg;
    logic           s1_pix;

    assign s1_pix = s1_valid_reg && (s1_cmd_reg == rmpa_pkg::CMD_PIXEL);

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            above_rd_reg     <= line_above[c_eff];
            two_above_rd_reg <= line_two_above[c_eff];
        end
        if (s1_pix)
        begin
            line_above[s1_c_reg]     <= s1_pix_reg;
            line_two_above[s1_c_reg] <= above_c;
        end
    end

    // columns are first written in ascending order, so the written ones form a prefix
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lb_fill_reg <= '0;
            lb_hit_reg  <= 1'b0;
        end
        else
        begin
            if (pix_acc)
            begin
                lb_hit_reg <= DWW'(c_eff) < lb_fill_reg;
            end
            if (s1_pix && (DWW'(s1_c_reg) == lb_fill_reg))
            begin
                lb_fill_reg <= lb_fill_reg + 1'b1;
            end
        end
    end

    assign above_c     = lb_hit_reg ? above_rd_reg : '0;
    assign two_above_c = lb_hit_reg ? two_above_rd_reg : '0;

    // window: 0 current row c-1, 1 row above c-1, 2 row above c-2, 3 two above c-1
    logic [LW-1:0] win0_reg, win1_reg, win2_reg, win3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg <= '0;
            win1_reg <= '0;
            win2_reg <= '0;
            win3_reg <= '0;
        end
        else if (s1_pix)
        begin
            win0_reg <= s1_pix_reg;
            win1_reg <= above_c;
            win2_reg <= win1_reg;
            win3_reg <= two_above_c;
        end
    end

    // moment store
    logic            pix_ok, q_ok, centre_ok, edge_hit;
    logic            mom_rd_en, mom_wr_en;
    logic [AW-1:0]   mom_rd_addr, mom_wr_addr;
    rmpa_pkg::moments_t mom_old, mom_new;
    logic [rmpa_pkg::AREA_W:0] area_sum;
    logic [rmpa_pkg::SUM_W:0]  sx_sum, sy_sum;

    assign mom_rd_en   = in_acc;
    assign mom_rd_addr = (items.cmd == rmpa_pkg::CMD_READ) ? AW'(items.query_label)
                                                           : AW'(items.pixel_label);

    assign pix_ok    = (s1_pix_reg != '0) && (32'(s1_pix_reg) < 32'(NUM_LABELS));
    assign q_ok      = (s1_q_reg != '0) && (32'(s1_q_reg) < 32'(NUM_LABELS));
    assign centre_ok = (win1_reg != '0) && (32'(win1_reg) < 32'(NUM_LABELS));

    always_comb
    begin
        area_sum = {1'b0, mom_old.area} + 1'b1;
        sx_sum   = {1'b0, mom_old.sum_x} + (rmpa_pkg::SUM_W + 1)'(s1_c_reg);
        sy_sum   = {1'b0, mom_old.sum_y} + (rmpa_pkg::SUM_W + 1)'(s1_r_reg);
        if (s1_cmd_reg == rmpa_pkg::CMD_READ)
        begin
            mom_new = '0;
        end
        else
        begin
            mom_new.area  = (area_sum > {1'b0, rmpa_pkg::AREA_MAX}) ? rmpa_pkg::AREA_MAX
                                                                    : area_sum[rmpa_pkg::AREA_W-1:0];
            mom_new.sum_x = (sx_sum > {1'b0, rmpa_pkg::SUM_MAX}) ? rmpa_pkg::SUM_MAX
                                                                 : sx_sum[rmpa_pkg::SUM_W-1:0];
            mom_new.sum_y = (sy_sum > {1'b0, rmpa_pkg::SUM_MAX}) ? rmpa_pkg::SUM_MAX
                                                                 : sy_sum[rmpa_pkg::SUM_W-1:0];
        end
    end

    assign mom_wr_en   = s1_valid_reg && ((s1_cmd_reg == rmpa_pkg::CMD_READ) ? q_ok : pix_ok);
    assign mom_wr_addr = (s1_cmd_reg == rmpa_pkg::CMD_READ) ? AW'(s1_q_reg) : AW'(s1_pix_reg);

    rmpa_rmw_store #(
        .DEPTH (NUM_LABELS),
        .WIDTH (MW)
    ) u_mom_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mom_rd_en),
        .rd_addr (mom_rd_addr),
        .wr_en   (mom_wr_en),
        .wr_addr (mom_wr_addr),
        .wr_data (mom_new),
        .rd_data (mom_old)
    );

    // perimeter verdict for the pixel up-left of the current one
    assign edge_hit = s1_pix && (s1_c_reg >= CW'(2)) && (s1_r_reg >= RW'(2)) && centre_ok
                      && !((win3_reg == win1_reg) && (win2_reg == win1_reg)
                           && (above_c == win1_reg) && (win0_reg == win1_reg));

    logic          per_rd_en;
    logic [AW-1:0] per_rd_addr;

    assign per_rd_en   = edge_hit || (s1_valid_reg && (s1_cmd_reg == rmpa_pkg::CMD_READ) && q_ok);
    assign per_rd_addr = (s1_cmd_reg == rmpa_pkg::CMD_READ) ? AW'(s1_q_reg) : AW'(win1_reg);

    // stage 2
    logic               s2_read_reg, s2_qok_reg, s2_hit_reg;
    logic [AW-1:0]      s2_addr_reg;
    rmpa_pkg::moments_t s2_mom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_read_reg <= 1'b0;
            s2_hit_reg  <= 1'b0;
        end
        else
        begin
            s2_read_reg <= s1_valid_reg && (s1_cmd_reg == rmpa_pkg::CMD_READ);
            s2_hit_reg  <= edge_hit;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_qok_reg  <= q_ok;
        s2_addr_reg <= per_rd_addr;
        s2_mom_reg  <= q_ok ? mom_old : '0;
    end

    logic [rmpa_pkg::PERIM_W-1:0] per_old, per_new;
    logic [rmpa_pkg::PERIM_W:0]   per_sum;
    logic                         per_wr_en;

    always_comb
    begin
        per_sum = {1'b0, per_old} + 1'b1;
        if (s2_read_reg)
        begin
            per_new = '0;
        end
        else
        begin
            per_new = (per_sum > {1'b0, rmpa_pkg::PERIM_MAX}) ? rmpa_pkg::PERIM_MAX
                                                              : per_sum[rmpa_pkg::PERIM_W-1:0];
        end
    end

    assign per_wr_en = s2_hit_reg || (s2_read_reg && s2_qok_reg);

    rmpa_rmw_store #(
        .DEPTH (NUM_LABELS),
        .WIDTH (rmpa_pkg::PERIM_W)
    ) u_per_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (per_rd_en),
        .rd_addr (per_rd_addr),
        .wr_en   (per_wr_en),
        .wr_addr (s2_addr_reg),
        .wr_data (per_new),
        .rd_data (per_old)
    );

    // result queue
    rmpa_pkg::result_t q_mem [QD];
    rmpa_pkg::result_t push_word;
    logic [1:0] wr_ptr_reg, rd_ptr_reg;
    logic [2:0] cnt_reg, in_flight;
    logic       push, pop;

    always_comb
    begin
        push_word.area      = s2_mom_reg.area;
        push_word.sum_x     = s2_mom_reg.sum_x;
        push_word.sum_y     = s2_mom_reg.sum_y;
        push_word.perimeter = s2_qok_reg ? per_old : '0;
    end

    assign push      = s2_read_reg;
    assign pop       = results.valid && results.ready;
    assign in_flight = cnt_reg + 3'(s2_read_reg)
                       + 3'(s1_valid_reg && (s1_cmd_reg == rmpa_pkg::CMD_READ));
    assign items.ready = in_flight < 3'(QD);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + 3'(push) - 3'(pop);
        end
    end

    assign results.valid     = cnt_reg != '0;
    assign results.area      = q_mem[rd_ptr_reg].area;
    assign results.sum_x     = q_mem[rd_ptr_reg].sum_x;
    assign results.sum_y     = q_mem[rd_ptr_reg].sum_y;
    assign results.perimeter = q_mem[rd_ptr_reg].perimeter;

endmodule
